// File: sv/hblp_pkg.sv
// Shared types and constants for the host byte load port.
// No dependencies; imported by hblp_core and host_byte_load_port.
package hblp_pkg;

    localparam int DEFAULT_PROGRAM_DEPTH = 256;
    localparam int DEFAULT_COEF_DEPTH    = 256;

    localparam logic [2:0] WORD24_BYTES = 3'd3;
    localparam logic [2:0] WORD32_BYTES = 3'd4;

    typedef enum logic [1:0] {
        KIND_PROG_PIN = 2'd0,
        KIND_COEF_PIN = 2'd1,
        KIND_DATA     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_ST0 = 2'd0,
        PHASE_ST1 = 2'd1,
        PHASE_PRG = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        TGT_ST0  = 3'd0,
        TGT_ST1  = 3'd1,
        TGT_PRG  = 3'd2,
        TGT_CSEQ = 3'd3,
        TGT_CADR = 3'd4
    } target_t;

    typedef struct packed {
        target_t     target;
        logic [7:0]  address;
        logic [31:0] value;
    } hblp_write_t;

endpackage

// File: sv/hblp_core.sv
// Load-mode state, byte assembly and pointer tracking of the host byte load port.
// Depends on hblp_pkg; one item is processed per enabled cycle.
module hblp_core #(
    parameter int PROGRAM_DEPTH = hblp_pkg::DEFAULT_PROGRAM_DEPTH,
    parameter int COEF_DEPTH    = hblp_pkg::DEFAULT_COEF_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [1:0]           kind,
    input  logic [7:0]           value,
    output logic                 wr_valid,
    output hblp_pkg::hblp_write_t wr
);
    import hblp_pkg::*;

    localparam int PRG_W = $clog2(PROGRAM_DEPTH);
    localparam int COEF_W = $clog2(COEF_DEPTH);

    logic             prog_active_reg, prog_active_next;
    logic             coef_active_reg, coef_active_next;
    phase_t           phase_reg, phase_next;
    logic             pending_reg, pending_next;
    logic [2:0]       count_reg, count_next;
    logic [PRG_W-1:0] prog_ptr_reg, prog_ptr_next;
    logic [COEF_W-1:0] coef_ptr_reg, coef_ptr_next;
    logic [COEF_W-1:0] coef_addr_reg, coef_addr_next;
    logic [7:0]       buf_reg [4];
    logic [7:0]       buf_view [4];
    logic             buf_we;
    logic [2:0]       count_push;
    logic             pin_act;
    logic [23:0]      word24;
    logic [31:0]      word32;
    logic [COEF_W-1:0] addr_mod [256];

    // address byte reduced to the coefficient space
    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        assign addr_mod[g] = COEF_W'(g % COEF_DEPTH);
    end

    assign count_push = count_reg + 3'd1;
    assign pin_act    = (value == 8'd0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            buf_view[i] = (buf_we && (count_reg[1:0] == 2'(i))) ? value : buf_reg[i];
        end
    end

    assign word24 = {buf_view[0], buf_view[1], buf_view[2]};
    assign word32 = {buf_view[0], buf_view[1], buf_view[2], buf_view[3]};

    always_comb
    begin
        prog_active_next = prog_active_reg;
        coef_active_next = coef_active_reg;
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        count_next       = count_reg;
        prog_ptr_next    = prog_ptr_reg;
        coef_ptr_next    = coef_ptr_reg;
        coef_addr_next   = coef_addr_reg;
        buf_we           = 1'b0;
        wr_valid         = 1'b0;
        wr               = '0;
        if (en)
        begin
            unique case (kind)
                KIND_PROG_PIN:
                begin
                    if (prog_active_reg != pin_act)
                    begin
                        prog_active_next = pin_act;
                        count_next       = 3'd0;
                    end
                end
                KIND_COEF_PIN:
                begin
                    if (coef_active_reg != pin_act)
                    begin
                        coef_active_next = pin_act;
                        count_next       = 3'd0;
                    end
                end
                KIND_DATA:
                begin
                    priority if (!prog_active_reg && !coef_active_reg)
                    begin
                        count_next   = 3'd0;
                        pending_next = 1'b0;
                    end
                    else if (prog_active_reg && !coef_active_reg)
                    begin
                        buf_we = 1'b1;
                        if (count_push >= WORD24_BYTES)
                        begin
                            count_next = 3'd0;
                            wr_valid   = 1'b1;
                            wr.value   = {8'd0, word24};
                            unique case (phase_reg)
                                PHASE_ST0:
                                begin
                                    phase_next = PHASE_ST1;
                                    wr.target  = TGT_ST0;
                                end
                                PHASE_ST1:
                                begin
                                    phase_next = PHASE_PRG;
                                    wr.target  = TGT_ST1;
                                end
                                default:
                                begin
                                    phase_next    = PHASE_PRG;
                                    wr.target     = TGT_PRG;
                                    wr.address    = 8'(prog_ptr_reg);
                                    prog_ptr_next = (prog_ptr_reg == PRG_W'(PROGRAM_DEPTH - 1))
                                                  ? '0 : prog_ptr_reg + PRG_W'(1);
                                end
                            endcase
                        end
                        else
                        begin
                            count_next = count_push;
                        end
                    end
                    else if (!prog_active_reg && coef_active_reg)
                    begin
                        if (pending_reg)
                        begin
                            buf_we     = 1'b1;
                            count_next = count_push;
                            if (count_push >= WORD32_BYTES)
                            begin
                                pending_next = 1'b0;
                                wr_valid     = 1'b1;
                                wr.target    = TGT_CADR;
                                wr.address   = 8'(coef_addr_reg);
                                wr.value     = word32;
                            end
                        end
                        else
                        begin
                            coef_addr_next = addr_mod[value];
                            count_next     = 3'd0;
                            pending_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        buf_we = 1'b1;
                        if (count_push >= WORD32_BYTES)
                        begin
                            count_next    = 3'd0;
                            wr_valid      = 1'b1;
                            wr.target     = TGT_CSEQ;
                            wr.address    = 8'(coef_ptr_reg);
                            wr.value      = word32;
                            coef_ptr_next = (coef_ptr_reg == COEF_W'(COEF_DEPTH - 1))
                                          ? '0 : coef_ptr_reg + COEF_W'(1);
                        end
                        else
                        begin
                            count_next = count_push;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_active_reg <= 1'b0;
            coef_active_reg <= 1'b0;
            phase_reg       <= PHASE_ST0;
            pending_reg     <= 1'b0;
            count_reg       <= 3'd0;
            prog_ptr_reg    <= '0;
            coef_ptr_reg    <= '0;
            coef_addr_reg   <= '0;
        end
        else
        begin
            prog_active_reg <= prog_active_next;
            coef_active_reg <= coef_active_next;
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            count_reg       <= count_next;
            prog_ptr_reg    <= prog_ptr_next;
            coef_ptr_reg    <= coef_ptr_next;
            coef_addr_reg   <= coef_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[count_reg[1:0]] <= value;
        end
    end

endmodule

// File: sv/host_byte_load_port.sv
// Top level of the host byte load port: input register, result register, handshake.
// Depends on hblp_pkg and hblp_core.

// One transfer is taken per cycle while in_stall is low. A transfer is
// captured in the input register and is decoded against the load-mode
// state by hblp_core while the result register is not held. A completed
// word is then loaded into the result register, which sets out_valid, so a
// result passes through the input and result registers. While the result
// register is full and stalled, the input register holds and in_stall
// rises once it is occupied.
module host_byte_load_port #(
    parameter int PROGRAM_DEPTH = hblp_pkg::DEFAULT_PROGRAM_DEPTH,
    parameter int COEF_DEPTH    = hblp_pkg::DEFAULT_COEF_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  write_target,
    output logic [7:0]  write_address,
    output logic [31:0] write_value
);
    import hblp_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  value_reg;
    logic        out_valid_reg;
    hblp_write_t out_reg;
    logic        hold;
    logic        proc_en;
    logic        wr_valid;
    hblp_write_t wr;

    assign hold     = out_valid_reg && out_stall;
    assign in_stall = in_valid_reg && hold;
    assign proc_en  = in_valid_reg && !hold;

    hblp_core #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .COEF_DEPTH    (COEF_DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (proc_en),
        .kind     (kind_reg),
        .value    (value_reg),
        .wr_valid (wr_valid),
        .wr       (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (!hold)
            begin
                out_valid_reg <= proc_en && wr_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (proc_en && wr_valid)
        begin
            out_reg <= wr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_target  = out_reg.target;
    assign write_address = out_reg.address;
    assign write_value   = out_reg.value;

endmodule

// File: sim/tb.sv
// Testbench for host_byte_load_port: checks written status, program and coefficient words.
// Depends on hblp_pkg and the RTL under sv/; a built-in predictor supplies expected writes.
module tb;
    import hblp_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] PIN_ACTIVE  = 8'h00;
    localparam int PROG_DEPTH  = DEFAULT_PROGRAM_DEPTH;
    localparam int COEF_DEPTH  = DEFAULT_COEF_DEPTH;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  write_target;
    logic [7:0]  write_address;
    logic [31:0] write_value;

    // predictor state
    bit          prog_mode;
    bit          coef_mode;
    phase_t      boot_phase;
    bit          addr_armed;
    logic [2:0]  nbytes;
    logic [7:0]  bytebuf [4];
    logic [7:0]  prog_ptr;
    logic [7:0]  cseq_ptr;
    logic [7:0]  cadr;

    hblp_write_t expected_writes [$];
    int          mismatches   = 0;
    bit          gaps_on      = 1'b1;
    bit          send_quiet   = 1'b0;
    int          sent_count   = 0;
    int          hold_request = 0;

    host_byte_load_port DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_target  (write_target),
        .write_address (write_address),
        .write_value   (write_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] pin_inactive();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        bytebuf[nbytes[1:0]] = b;
        nbytes = nbytes + 3'd1;
    endtask

    task automatic predict_write(input logic [1:0] k, input logic [7:0] v);
        hblp_write_t w;
        bit          on;
        on = (v == PIN_ACTIVE);
        case (k)
            KIND_PROG_PIN:
                if (prog_mode != on)
                begin
                    prog_mode = on;
                    nbytes = '0;
                end
            KIND_COEF_PIN:
                if (coef_mode != on)
                begin
                    coef_mode = on;
                    nbytes = '0;
                end
            KIND_DATA:
                if (!prog_mode && !coef_mode)
                begin
                    nbytes = '0;
                    addr_armed = 1'b0;
                end
                else if (prog_mode && !coef_mode)
                begin
                    push_byte(v);
                    if (nbytes >= WORD24_BYTES)
                    begin
                        nbytes = '0;
                        w.value = {8'h00, bytebuf[0], bytebuf[1], bytebuf[2]};
                        w.address = 8'h00;
                        case (boot_phase)
                            PHASE_ST0:
                            begin
                                w.target = TGT_ST0;
                                boot_phase = PHASE_ST1;
                            end
                            PHASE_ST1:
                            begin
                                w.target = TGT_ST1;
                                boot_phase = PHASE_PRG;
                            end
                            default:
                            begin
                                w.target = TGT_PRG;
                                w.address = prog_ptr;
                                prog_ptr = 8'((int'(prog_ptr) + 1) % PROG_DEPTH);
                                boot_phase = PHASE_PRG;
                            end
                        endcase
                        expected_writes.push_back(w);
                    end
                end
                else if (!prog_mode)
                begin
                    if (addr_armed)
                    begin
                        push_byte(v);
                        if (nbytes >= WORD32_BYTES)
                        begin
                            addr_armed = 1'b0;
                            w.target = TGT_CADR;
                            w.address = cadr;
                            w.value = {bytebuf[0], bytebuf[1], bytebuf[2], bytebuf[3]};
                            expected_writes.push_back(w);
                        end
                    end
                    else
                    begin
                        cadr = 8'(int'(v) % COEF_DEPTH);
                        nbytes = '0;
                        addr_armed = 1'b1;
                    end
                end
                else
                begin
                    push_byte(v);
                    if (nbytes >= WORD32_BYTES)
                    begin
                        nbytes = '0;
                        w.target = TGT_CSEQ;
                        w.address = cseq_ptr;
                        w.value = {bytebuf[0], bytebuf[1], bytebuf[2], bytebuf[3]};
                        expected_writes.push_back(w);
                        cseq_ptr = 8'((int'(cseq_ptr) + 1) % COEF_DEPTH);
                    end
                end
            default: ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input logic [1:0] k, input logic [7:0] v);
        int gap;
        sent_count++;
        if (sent_count % 64 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        gap = (gaps_on && !send_quiet) ? pick_idle() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        predict_write(k, v);
    endtask

    task automatic send_noise(input bit prog_on, input bit coef_on);
        logic [1:0] pin;
        logic [7:0] level;
        pin = $urandom_range(0, 1) ? KIND_COEF_PIN : KIND_PROG_PIN;
        level = ((pin == KIND_PROG_PIN) ? prog_on : coef_on) ? PIN_ACTIVE : pin_inactive();
        case ($urandom_range(0, 2))
            0: send_item(KIND_UNUSED, 8'($urandom));
            1: send_item(pin, level);
            default:
            begin
                repeat ($urandom_range(1, 3)) send_item(KIND_DATA, 8'($urandom));
                send_item(pin, (level == PIN_ACTIVE) ? pin_inactive() : PIN_ACTIVE);
                if ($urandom_range(0, 1))
                    send_item(KIND_DATA, 8'($urandom));
                send_item(pin, level);
            end
        endcase
    endtask

    task automatic test_directed_cases();
        send_item(KIND_DATA, 8'h5A);        // no mode: dropped
        send_item(KIND_UNUSED, 8'hAA);
        send_item(KIND_PROG_PIN, PIN_ACTIVE);
        send_item(KIND_PROG_PIN, PIN_ACTIVE);   // repeated level
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hA5);
        send_item(KIND_DATA, 8'h5A);
        send_item(KIND_DATA, 8'hC3);
        send_item(KIND_COEF_PIN, PIN_ACTIVE);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'h01);
        send_item(KIND_PROG_PIN, 8'h01);
        send_item(KIND_DATA, 8'hFF);        // address
        send_item(KIND_DATA, 8'hDE);
        send_item(KIND_DATA, 8'hAD);
        send_item(KIND_DATA, 8'hBE);
        send_item(KIND_DATA, 8'hEF);
        send_item(KIND_DATA, 8'h10);        // this byte is a new address
        send_item(KIND_COEF_PIN, 8'hFF);
    endtask

    task automatic test_program_load(input int words);
        send_item(KIND_PROG_PIN, PIN_ACTIVE);
        send_item(KIND_COEF_PIN, pin_inactive());
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise(1'b1, 1'b0);
            repeat (3) send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    task automatic test_coef_addressed(input int words);
        send_item(KIND_PROG_PIN, pin_inactive());
        send_item(KIND_COEF_PIN, PIN_ACTIVE);
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_noise(1'b0, 1'b1);
            repeat (5) send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    task automatic test_coef_sequential(input int words);
        send_item(KIND_PROG_PIN, PIN_ACTIVE);
        send_item(KIND_COEF_PIN, PIN_ACTIVE);
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise(1'b1, 1'b1);
            repeat (4) send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    task automatic test_stalled_output(input int words);
        send_item(KIND_PROG_PIN, PIN_ACTIVE);
        send_item(KIND_COEF_PIN, PIN_ACTIVE);
        gaps_on = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (4 * words) send_item(KIND_DATA, 8'($urandom));
        gaps_on = 1'b1;
    endtask

    task automatic test_random_modes(input int items);
        int r;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_item(KIND_PROG_PIN, $urandom_range(0, 1) ? PIN_ACTIVE : pin_inactive());
            else if (r < 60)
                send_item(KIND_COEF_PIN, $urandom_range(0, 1) ? PIN_ACTIVE : pin_inactive());
            else if (r < 95)
                send_item(KIND_DATA, 8'($urandom));
            else
                send_item(KIND_UNUSED, 8'($urandom));
        end
    endtask

    // result side: stall pattern and comparison against the oldest expected write
    initial
    begin : result_side
        hblp_write_t exp_w;
        int          stall_left;
        int          cycle_count;
        bit          recv_quiet;
        stall_left  = 0;
        cycle_count = 0;
        recv_quiet  = 1'b0;
        out_stall   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write: write_target %0d write_address %0d write_value %h",
                           write_target, write_address, write_value);
                    mismatches++;
                end
                else
                begin
                    exp_w = expected_writes.pop_front();
                    if (write_target !== exp_w.target)
                    begin
                        $error("write_target: expected %0d, got %0d", exp_w.target, write_target);
                        mismatches++;
                    end
                    if (write_address !== exp_w.address)
                    begin
                        $error("write_address: expected %0d, got %0d",
                               exp_w.address, write_address);
                        mismatches++;
                    end
                    if (write_value !== exp_w.value)
                    begin
                        $error("write_value: expected %h, got %h", exp_w.value, write_value);
                        mismatches++;
                    end
                end
            end
            cycle_count++;
            if (cycle_count % 64 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left == 0)
                stall_left = recv_quiet ? 0 : pick_idle();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_PROG_PIN;
        value      = 8'h00;
        prog_mode  = 1'b0;
        coef_mode  = 1'b0;
        boot_phase = PHASE_ST0;
        addr_armed = 1'b0;
        nbytes     = '0;
        bytebuf    = '{default: 8'h00};
        prog_ptr   = 8'h00;
        cseq_ptr   = 8'h00;
        cadr       = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_program_load(256);
        test_coef_addressed(20);
        test_coef_sequential(240);
        test_stalled_output(16);
        test_random_modes(120);

        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
